/* rtl/cdfvr_pkg.sv */
package cdfvr_pkg;

    // Operand and product widths of the shared multiplier.
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 11;
    localparam int MIX_W    = 7;
    localparam int QUO_W    = 17;

    // Volume quantization masks and reset values.
    localparam logic [VOL_W-1:0] VOL_MASK_HI = 11'h7fc;
    localparam logic [VOL_W-1:0] VOL_MASK_LO = 11'h003;
    localparam logic [VOL_W-1:0] FULL_VOLUME = 11'h400;
    localparam logic [MIX_W-1:0] FULL_MIX    = 7'd100;

    // Divide by 100 as a multiply by floor(2^30 / 100) and a shift by 30.
    localparam logic [MUL_W-1:0] RECIP_100   = 24'd10737418;
    localparam int               RECIP_SHIFT = 30;
    localparam int               FADE_SHIFT  = 10;

    // Saturation limits of a 16-bit signed result.
    localparam logic [QUO_W-1:0]    MAG_POS_MAX = 17'd32767;
    localparam logic [QUO_W-1:0]    MAG_NEG_MAX = 17'd32768;
    localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_NEG     = 16'h8000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_TARGET_VOLUME = 1'b0,
        CFG_MIX_PERCENT   = 1'b1
    } t_cfg_idx;

    // Steps of one channel through the shared multiplier.
    typedef enum logic [1:0] {
        PH_FADE  = 2'd0,
        PH_MIX   = 2'd1,
        PH_RECIP = 2'd2,
        PH_FIX   = 2'd3
    } t_phase;

endpackage

/* rtl/cdfvr_mul.sv */
module cdfvr_mul
    import cdfvr_pkg::*;
(
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);

    // Unsigned product; the caller registers it.
    assign o_p = {{MUL_W{1'b0}}, i_a} * {{MUL_W{1'b0}}, i_b};

endmodule

/* rtl/cdda_fader_volume_ramp.sv */
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_ready    | i_left_sample, i_right_sample, i_playing
// output   | out       | o_out_valid / i_out_ready  | o_left_out, o_right_out
// config   | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A word is taken only while the block is idle, and the next word waits until
// its last step is done: each channel, left then right, passes four steps (fade,
// mix, divide by 100, correction) around one shared 24x24 multiplier.
// The result word sits in an output register, so a new word is accepted while
// the previous result waits; the last step holds until that register is free.
// Reset is synchronous and active low and sets full volume and 100 percent mix.
module cdda_fader_volume_ramp
    import cdfvr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [VOL_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    input  logic                       i_playing,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_left_out,
    output logic signed [SAMPLE_W-1:0] o_right_out
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state               r_state;
    t_phase               r_phase;
    logic                 r_chan;
    logic [VOL_W-1:0]     r_tgt_vol;
    logic [MIX_W-1:0]     r_mix;
    logic [VOL_W-1:0]     r_cur_vol;
    logic [VOL_W-1:0]     r_mulq;
    logic [SAMPLE_W-1:0]  r_mag_l;
    logic [SAMPLE_W-1:0]  r_mag_r;
    logic                 r_neg_l;
    logic                 r_neg_r;
    logic [MUL_W-1:0]     r_acc;
    logic [QUO_W-1:0]     r_quo;
    logic [SAMPLE_W-1:0]  r_res_l;
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_l;
    logic [SAMPLE_W-1:0]  r_out_r;

    logic [VOL_W-1:0]     n_cur_vol;
    logic [VOL_W-1:0]     n_mulq;
    logic                 w_accept;
    logic                 w_out_free;
    logic [SAMPLE_W-1:0]  w_mag_l;
    logic [SAMPLE_W-1:0]  w_mag_r;
    logic [SAMPLE_W-1:0]  w_mag;
    logic                 w_neg;
    logic [MUL_W-1:0]     w_mul_a;
    logic [MUL_W-1:0]     w_mul_b;
    logic [PROD_W-1:0]    w_prod;
    logic [MUL_W:0]       w_q100;
    logic [MUL_W:0]       w_rem;
    logic [QUO_W-1:0]     w_q_fix;
    logic [SAMPLE_W-1:0]  w_res;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = $signed(r_out_l);
    assign o_right_out = $signed(r_out_r);

    // Sample magnitudes; truncation toward zero is a floor on the magnitude.
    assign w_mag_l = i_left_sample[SAMPLE_W-1]
                   ? (16'd0 - $unsigned(i_left_sample)) : $unsigned(i_left_sample);
    assign w_mag_r = i_right_sample[SAMPLE_W-1]
                   ? (16'd0 - $unsigned(i_right_sample)) : $unsigned(i_right_sample);

    // Quantized fader multiplier and the volume step toward the setpoint.
    always_comb begin
        if (!i_playing) begin
            n_mulq = '0;
        end else if ((r_cur_vol & VOL_MASK_HI) != '0) begin
            n_mulq = r_cur_vol & VOL_MASK_HI;
        end else begin
            n_mulq = r_cur_vol & VOL_MASK_LO;
        end
        if (!i_playing) begin
            n_cur_vol = r_cur_vol;
        end else if (r_cur_vol < r_tgt_vol) begin
            n_cur_vol = r_cur_vol + 11'd1;
        end else if (r_cur_vol > r_tgt_vol) begin
            n_cur_vol = r_cur_vol - 11'd1;
        end else begin
            n_cur_vol = r_cur_vol;
        end
    end

    assign w_mag = r_chan ? r_mag_r : r_mag_l;
    assign w_neg = r_chan ? r_neg_r : r_neg_l;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_phase)
            PH_FADE: begin
                w_mul_a = {{(MUL_W-SAMPLE_W){1'b0}}, w_mag};
                w_mul_b = {{(MUL_W-VOL_W){1'b0}}, r_mulq};
            end
            PH_MIX: begin
                w_mul_a = {{(MUL_W-QUO_W){1'b0}}, r_acc[QUO_W-1:0]};
                w_mul_b = {{(MUL_W-MIX_W){1'b0}}, r_mix};
            end
            PH_RECIP: begin
                w_mul_a = r_acc;
                w_mul_b = RECIP_100;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    cdfvr_mul u_mul (
        .i_a (w_mul_a),
        .i_b (w_mul_b),
        .o_p (w_prod)
    );

    // The reciprocal quotient can be one short; fix it, then apply sign and clamp.
    always_comb begin
        w_q100  = ({8'd0, r_quo} << 6) + ({8'd0, r_quo} << 5) + ({8'd0, r_quo} << 2);
        w_rem   = {1'b0, r_acc} - w_q100;
        w_q_fix = r_quo + {{(QUO_W-1){1'b0}}, (w_rem >= 25'd100)};
        if (!w_neg) begin
            w_res = (w_q_fix > MAG_POS_MAX) ? SAT_POS : w_q_fix[SAMPLE_W-1:0];
        end else begin
            w_res = (w_q_fix > MAG_NEG_MAX) ? SAT_NEG : (16'd0 - w_q_fix[SAMPLE_W-1:0]);
        end
    end

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FADE;
            r_chan      <= 1'b0;
            r_tgt_vol   <= FULL_VOLUME;
            r_mix       <= FULL_MIX;
            r_cur_vol   <= FULL_VOLUME;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_TARGET_VOLUME: r_tgt_vol <= i_cfg_data;
                    CFG_MIX_PERCENT:   r_mix     <= i_cfg_data[MIX_W-1:0];
                    default:           r_mix     <= r_mix;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mag_l   <= w_mag_l;
                        r_mag_r   <= w_mag_r;
                        r_neg_l   <= i_left_sample[SAMPLE_W-1];
                        r_neg_r   <= i_right_sample[SAMPLE_W-1];
                        r_mulq    <= n_mulq;
                        r_cur_vol <= n_cur_vol;
                        r_chan    <= 1'b0;
                        r_phase   <= PH_FADE;
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    unique case (r_phase)
                        PH_FADE: begin
                            r_acc   <= {{(MUL_W-QUO_W){1'b0}},
                                        w_prod[FADE_SHIFT+QUO_W-1:FADE_SHIFT]};
                            r_phase <= PH_MIX;
                        end
                        PH_MIX: begin
                            r_acc   <= w_prod[MUL_W-1:0];
                            r_phase <= PH_RECIP;
                        end
                        PH_RECIP: begin
                            r_quo   <= w_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
                            r_phase <= PH_FIX;
                        end
                        PH_FIX: begin
                            if (!r_chan) begin
                                r_res_l <= w_res;
                                r_chan  <= 1'b1;
                                r_phase <= PH_FADE;
                            end else if (w_out_free) begin
                                r_out_l     <= r_res_l;
                                r_out_r     <= w_res;
                                r_out_valid <= 1'b1;
                                r_state     <= S_IDLE;
                            end
                        end
                        default: r_phase <= PH_FADE;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The volume moves only when a playing word is accepted.
    a_vol_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && i_playing) |=> $stable(r_cur_vol))
        else $error("fader volume changed without a played word");

    // The volume moves by at most one step per word.
    a_vol_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_cur_vol == $past(r_cur_vol))
                  || (r_cur_vol == $past(r_cur_vol) + 11'd1)
                  || (r_cur_vol == $past(r_cur_vol) - 11'd1))
        else $error("fader volume moved by more than one step");

    // The reciprocal quotient is never more than one short.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_phase == PH_FIX) |-> (w_rem < 25'd200))
        else $error("divide by 100 correction out of range");

    // A result appears only at the end of a computation.
    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RUN && $past(r_chan)))
        else $error("result word raised outside the last step");

endmodule

/* tb/tb_cdda_fader_volume_ramp.sv */
module tb_cdda_fader_volume_ramp;
    import cdfvr_pkg::*;

    localparam longint FADER_DIV    = 1024;
    localparam longint MIX_DIV      = 100;
    localparam int     VOL_MAX      = 2047;
    localparam int     MIX_MAX      = 127;
    localparam int     GAP_MAX      = 18;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     RANDOM_WORDS = 560;
    localparam int     RAMP_SPAN    = 64;
    localparam int     REPORT_MAX   = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_stereo_pair;

    logic                       i_clk;
    logic                       i_rst_n    = 1'b0;
    logic                       cfg_we     = 1'b0;
    t_cfg_idx                   cfg_idx    = CFG_TARGET_VOLUME;
    logic [VOL_W-1:0]           cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] left_in    = '0;
    logic signed [SAMPLE_W-1:0] right_in   = '0;
    logic                       playing_in = 1'b0;
    logic                       o_out_valid;
    logic                       out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;

    // Local copy of the fader state and its two registers, plus the range swept.
    logic [VOL_W-1:0] vol_now  = FULL_VOLUME;
    logic [VOL_W-1:0] tgt_vol  = FULL_VOLUME;
    logic [MIX_W-1:0] mix_pct  = FULL_MIX;
    logic [VOL_W-1:0] vol_lo   = FULL_VOLUME;
    logic [VOL_W-1:0] vol_hi   = FULL_VOLUME;

    t_stereo_pair expected_pairs[$];

    int  error_count  = 0;
    int  report_count = 0;
    int  words_sent   = 0;
    int  words_played = 0;
    int  words_seen   = 0;
    int  reg_writes   = 0;
    int  sink_hold    = 0;
    bit  no_idle      = 1'b0;
    bit  held_long    = 1'b0;

    cdda_fader_volume_ramp u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_sample  (left_in),
        .i_right_sample (right_in),
        .i_playing      (playing_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #8000000;
        $display("tb_cdda_fader_volume_ramp failed");
        $finish;
    end

    // Idle cycles before one word; at least a quarter of the draws give none, and all do while no_idle is set.
    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Mostly full-range samples, with extremes and values around zero mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'($urandom_range(0, 31)) - SAMPLE_W'(16);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // One channel: fader gain over 1024, then mix over 100, both toward zero,
    // then clipped to the 16-bit range.
    function automatic logic signed [SAMPLE_W-1:0] scale_channel(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [VOL_W-1:0]           gain
    );
        longint x;
        x = longint'(s) * longint'(gain);
        x = x / FADER_DIV;
        x = (x * longint'(mix_pct)) / MIX_DIV;
        if (x > 32767)
            return SAT_POS;
        if (x < -32768)
            return SAT_NEG;
        return SAMPLE_W'(x);
    endfunction

    // Work out the faded pair for an accepted word and step the volume ramp.
    task automatic predict_fade(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r,
        input logic                       p
    );
        t_stereo_pair pair;
        logic [VOL_W-1:0] gain;
        pair = '0;
        if (p) begin
            gain = vol_now & VOL_MASK_HI;
            if (gain == '0)
                gain = vol_now & VOL_MASK_LO;
            pair.left  = scale_channel(l, gain);
            pair.right = scale_channel(r, gain);
            if (vol_now < tgt_vol)
                vol_now = vol_now + 1'b1;
            else if (vol_now > tgt_vol)
                vol_now = vol_now - 1'b1;
            if (vol_now < vol_lo)
                vol_lo = vol_now;
            if (vol_now > vol_hi)
                vol_hi = vol_now;
            words_played++;
        end
        expected_pairs.push_back(pair);
    endtask

    // Offer one word after a random gap and wait until it is taken. Valid stays
    // high on return so that a following word can go out without a gap.
    task automatic send_word(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r,
        input logic                       p
    );
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        left_in    <= l;
        right_in   <= r;
        playing_in <= p;
        do @(posedge i_clk); while (!o_in_ready);
        predict_fade(l, r, p);
        words_sent++;
    endtask

    // Must follow the last send_word directly, in the same time step.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Register write, only issued while the block is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [VOL_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET_VOLUME: tgt_vol = value;
            CFG_MIX_PERCENT:   mix_pct = value[MIX_W-1:0];
            default:           ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Sample extremes, silence, the settled ramp, mix extremes and clipping.
    task automatic test_directed();
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(16'sh8000, 16'sh7fff, 1'b1);
        send_word(16'sh0000, -16'sd1, 1'b1);
        send_word(16'sd1, -16'sd1, 1'b1);
        send_word(16'sd12345, -16'sd12345, 1'b0);
        drain_results();

        // Setpoint above full volume with mix above 100 drives both channels into clipping.
        write_reg(CFG_TARGET_VOLUME, 11'd1026);
        write_reg(CFG_MIX_PERCENT, VOL_W'(MIX_MAX));
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(16'sh8000, 16'sh7fff, 1'b1);
        send_word(16'sd500, -16'sd500, 1'b0);
        drain_results();

        // Zero mix mutes the output while the volume still ramps down.
        write_reg(CFG_TARGET_VOLUME, 11'd0);
        write_reg(CFG_MIX_PERCENT, 11'd0);
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(-16'sd7, 16'sd7, 1'b1);
        drain_results();

        write_reg(CFG_MIX_PERCENT, 11'd1);
        send_word(16'sh7fff, 16'sh8000, 1'b1);
        send_word(-16'sd100, 16'sd100, 1'b1);
        drain_results();

        write_reg(CFG_MIX_PERCENT, 11'd50);
        send_word(16'sh8000, 16'sh8000, 1'b1);
        send_word(16'sh7fff, 16'sh7fff, 1'b1);
        send_word(16'sh5555, 16'shaaaa, 1'b1);
        drain_results();
    endtask

    // Ramp up past full volume until the setpoint is reached, then ramp down
    // below full volume with the mix above 100.
    task automatic test_full_ramp();
        no_idle = 1'b1;
        write_reg(CFG_TARGET_VOLUME, FULL_VOLUME + VOL_W'(RAMP_SPAN));
        write_reg(CFG_MIX_PERCENT, VOL_W'(FULL_MIX));
        while (vol_now != tgt_vol)
            send_word(pick_sample(), pick_sample(), $urandom_range(0, 15) != 0);
        repeat (4) send_word(pick_sample(), pick_sample(), 1'b1);
        drain_results();

        no_idle = 1'b0;
        write_reg(CFG_TARGET_VOLUME, FULL_VOLUME - VOL_W'(RAMP_SPAN));
        write_reg(CFG_MIX_PERCENT, VOL_W'(MIX_MAX));
        while (vol_now != tgt_vol)
            send_word(pick_sample(), pick_sample(), $urandom_range(0, 15) != 0);
        repeat (6) send_word(pick_sample(), pick_sample(), 1'b1);
        drain_results();
    endtask

    // Random phases, each of which may write fresh register values and picks its own idling style.
    task automatic test_random();
        int count;
        int len;
        int t;
        count = 0;
        while (count < RANDOM_WORDS) begin
            case ($urandom_range(0, 5))
                0:       t = 0;
                1:       t = VOL_MAX;
                2:       t = FULL_VOLUME;
                3:       t = int'(vol_now) + $urandom_range(0, 80) - 40;
                default: t = $urandom_range(0, VOL_MAX);
            endcase
            if (t < 0)
                t = 0;
            if (t > VOL_MAX)
                t = VOL_MAX;
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_TARGET_VOLUME, VOL_W'(t));
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 6))
                    0:       write_reg(CFG_MIX_PERCENT, 11'd0);
                    1:       write_reg(CFG_MIX_PERCENT, 11'd100);
                    2:       write_reg(CFG_MIX_PERCENT, VOL_W'(MIX_MAX));
                    3:       write_reg(CFG_MIX_PERCENT, 11'd1);
                    default: write_reg(CFG_MIX_PERCENT, VOL_W'($urandom_range(0, MIX_MAX)));
                endcase
            end
            no_idle = ($urandom_range(0, 4) == 0);
            len = $urandom_range(10, 60);
            repeat (len) begin
                send_word(pick_sample(), pick_sample(), $urandom_range(0, 6) != 0);
                count++;
            end
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    // The sink stops for a long stretch while words keep coming, so the block
    // fills up and has to hold off its input.
    task automatic test_backpressure();
        write_reg(CFG_TARGET_VOLUME, FULL_VOLUME);
        write_reg(CFG_MIX_PERCENT, VOL_W'(FULL_MIX));
        sink_hold = HOLD_CYCLES;
        no_idle   = 1'b1;
        repeat (30) send_word(pick_sample(), pick_sample(), $urandom_range(0, 7) != 0);
        drain_results();
        no_idle = 1'b0;
    endtask

    // Result sink: random stalls per word, plus the one long hold when asked.
    initial begin : result_sink
        int stall;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
                held_long = 1'b1;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare every accepted result word with the oldest expected pair.
    always @(posedge i_clk) begin : result_check
        t_stereo_pair want;
        if (i_rst_n && o_out_valid && out_ready) begin
            words_seen++;
            if (expected_pairs.size() == 0) begin
                error_count++;
                if (report_count < REPORT_MAX)
                    $display("unexpected result word: L=%0d R=%0d", o_left_out, o_right_out);
                report_count++;
            end else begin
                want = expected_pairs.pop_front();
                if (o_left_out !== want.left || o_right_out !== want.right) begin
                    error_count++;
                    if (report_count < REPORT_MAX)
                        $display("word %0d mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 words_seen, want.left, want.right, o_left_out, o_right_out);
                    report_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_ramp();
        test_random();
        test_backpressure();
        repeat (40) @(posedge i_clk);
        if (expected_pairs.size() != 0) begin
            error_count++;
            $display("%0d expected words never arrived", expected_pairs.size());
        end
        $display("Run covered %0d words (%0d played), %0d register writes, %0d errors.",
                 words_sent, words_played, reg_writes, error_count);
        $display("Fader volume swept %0d..%0d; long sink hold applied: %0d.",
                 vol_lo, vol_hi, held_long);
        if (error_count == 0)
            $display("tb_cdda_fader_volume_ramp passed");
        else
            $display("tb_cdda_fader_volume_ramp failed");
        $finish;
    end

endmodule
